/* src/setrl_pkg.sv */
package setrl_pkg;

    // Default number of records held in the ring.
    localparam int unsigned DEF_LOG_DEPTH = 256;

    // Reset value of the minimum valid anchor time.
    localparam logic [31:0] VALID_TIME_MIN_RESET = 32'd1000000000;

    // Request codes.
    localparam logic [2:0] REQ_START     = 3'd0;
    localparam logic [2:0] REQ_EVENT     = 3'd1;
    localparam logic [2:0] REQ_END       = 3'd2;
    localparam logic [2:0] REQ_DELETE    = 3'd3;
    localparam logic [2:0] REQ_READ      = 3'd4;
    localparam logic [2:0] REQ_UPD_START = 3'd5;
    localparam logic [2:0] REQ_UPD_END   = 3'd6;

    // Record kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef struct packed {
        logic [31:0] session;
        logic [31:0] elapsed;
        logic [31:0] anchor;
        logic [1:0]  kind;
    } t_rec;

    localparam int unsigned REC_W = $bits(t_rec);

    typedef struct packed {
        logic        ok;
        logic [31:0] new_session_id;
        t_rec        rec;
    } t_result;

endpackage

/* src/setrl_if.sv */
interface setrl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] session_id;
    logic [31:0] elapsed_sec;
    logic [31:0] anchor_epoch;
    logic [7:0]  read_index;

    modport source (
        output valid, req_type, session_id, elapsed_sec, anchor_epoch, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, session_id, elapsed_sec, anchor_epoch, read_index,
        output ready
    );
endinterface

interface setrl_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] new_session_id;
    logic [31:0] rec_session;
    logic [31:0] rec_elapsed;
    logic [31:0] rec_anchor;
    logic [1:0]  rec_kind;

    modport source (
        output valid, ok, new_session_id, rec_session, rec_elapsed, rec_anchor, rec_kind,
        input  ready
    );
    modport sink (
        input  valid, ok, new_session_id, rec_session, rec_elapsed, rec_anchor, rec_kind,
        output ready
    );
endinterface

/* src/setrl_ram.sv */
module setrl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/setrl_addr.sv */
module setrl_addr #(
    parameter int unsigned LOG_DEPTH = setrl_pkg::DEF_LOG_DEPTH,
    localparam int unsigned AW = $clog2(LOG_DEPTH),
    localparam int unsigned CW = $clog2(LOG_DEPTH + 1)
) (
    input  logic [AW-1:0] i_wp,
    input  logic [CW-1:0] i_back,
    output logic [AW-1:0] o_phys
);

    // Physical slot that lies i_back records behind the write pointer,
    // modulo the ring depth. i_back runs from 1 to LOG_DEPTH.
    logic [CW:0] diff;
    logic [CW:0] wrapped;

    always_comb begin
        diff    = (CW + 1)'(i_wp) - (CW + 1)'(i_back);
        wrapped = diff + (CW + 1)'(LOG_DEPTH);
        o_phys  = diff[CW] ? wrapped[AW-1:0] : diff[AW-1:0];
    end

endmodule

/* src/session_tagged_event_ring_log.sv */
// Session-tagged event ring log.
//
// Requests arrive on i_req as one word each (valid/ready). Each request gives
// exactly one response word on o_rsp. Start, event and end append a record;
// when the ring is full the oldest record is overwritten. Delete-last pops the
// newest record if it is an event of the given session. Read returns a record
// by chronological index. The two anchor updates walk backward through the
// newest session and rewrite the anchor of the first record of the wanted kind.
//
// The block takes one request at a time. All records sit in a single RAM with one write and
// one registered read port; reads and anchor rewrites go through one shared back-offset address
// unit, appends to the write pointer. Appends and refused requests pass from decode to done; a
// read in range or delete on a filled ring passes issue and check, and an anchor update passes
// them once per record visited (at most the fill count): RAM read in issue, compare in check.
// The response word loads from done, and the next request is taken once the block is idle again.
//
// Reset clears the pointers and counters and sets the next session id to one;
// the record RAM is not cleared, and there is no start-up sweep. A finished
// response waits in an output register while the receiver stalls; the next
// request is still accepted, and its response waits until that register frees.
module session_tagged_event_ring_log #(
    parameter int unsigned LOG_DEPTH = setrl_pkg::DEF_LOG_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    setrl_req_if.sink           i_req,
    setrl_rsp_if.source         o_rsp,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data
);

    import setrl_pkg::*;

    localparam int unsigned AW = $clog2(LOG_DEPTH);
    localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // Control state.
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_back, n_back;
    logic [31:0]   r_next, n_next;
    logic [31:0]   r_vtm;
    logic          r_out_valid, n_out_valid;

    // Payload registers of the request in progress and of the response.
    logic [2:0]    r_type;
    logic [31:0]   r_sid;
    logic [31:0]   r_el;
    logic [31:0]   r_anc;
    logic [7:0]    r_idx;
    t_result       r_res, n_res;
    t_result       r_out, n_out;

    // RAM and address unit hookup.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_rec          ram_wdata;
    t_rec          ram_rdata;
    logic [AW-1:0] phys;
    logic          is_append;
    logic [1:0]    want_kind;
    logic [31:0]   start_id;
    logic [AW-1:0] wp_inc;

    setrl_addr #(.LOG_DEPTH(LOG_DEPTH)) u_addr (
        .i_wp   (r_wp),
        .i_back (r_back),
        .o_phys (phys)
    );

    setrl_ram #(.WIDTH(REC_W), .DEPTH(LOG_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_ISSUE),
        .i_raddr (phys),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.ok             = r_out.ok;
    assign o_rsp.new_session_id = r_out.new_session_id;
    assign o_rsp.rec_session    = r_out.rec.session;
    assign o_rsp.rec_elapsed    = r_out.rec.elapsed;
    assign o_rsp.rec_anchor     = r_out.rec.anchor;
    assign o_rsp.rec_kind       = r_out.rec.kind;

    assign is_append = (r_type == REQ_START) || (r_type == REQ_EVENT) || (r_type == REQ_END);
    assign want_kind = (r_type == REQ_UPD_START) ? KIND_START : KIND_END;
    // Session id zero is never handed out; on wrap the id becomes one.
    assign start_id  = (r_next == 32'd0) ? 32'd1 : r_next;
    assign wp_inc    = (r_wp == AW'(LOG_DEPTH - 1)) ? '0 : r_wp + AW'(1);

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_back      = r_back;
        n_next      = r_next;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = phys;
        ram_wdata   = ram_rdata;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res   = '0;
                n_state = S_DONE;
                if (is_append) begin
                    ram_we            = 1'b1;
                    ram_waddr         = r_wp;
                    ram_wdata.session = r_sid;
                    ram_wdata.elapsed = r_el;
                    ram_wdata.anchor  = r_anc;
                    ram_wdata.kind    = KIND_END;
                    if (r_type == REQ_START) begin
                        ram_wdata.session    = start_id;
                        ram_wdata.elapsed    = '0;
                        ram_wdata.kind       = KIND_START;
                        n_res.new_session_id = start_id;
                        n_next               = (r_next == 32'd0) ? 32'd2 : r_next + 32'd1;
                    end else if (r_type == REQ_EVENT) begin
                        ram_wdata.anchor = '0;
                        ram_wdata.kind   = KIND_EVENT;
                    end
                    n_res.ok = 1'b1;
                    n_wp     = wp_inc;
                    if (r_fill != CW'(LOG_DEPTH)) begin
                        n_fill = r_fill + CW'(1);
                    end
                end else if (r_type == REQ_DELETE) begin
                    if (r_fill != '0) begin
                        n_back  = CW'(1);
                        n_state = S_ISSUE;
                    end
                end else if (r_type == REQ_READ) begin
                    if (32'(r_idx) < 32'(r_fill)) begin
                        n_back  = r_fill - CW'(r_idx);
                        n_state = S_ISSUE;
                    end
                end else if (r_type == REQ_UPD_START || r_type == REQ_UPD_END) begin
                    if (r_anc > r_vtm && r_fill != '0) begin
                        n_back  = CW'(1);
                        n_state = S_ISSUE;
                    end
                end
            end

            S_ISSUE: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_state = S_DONE;
                if (r_type == REQ_DELETE) begin
                    // The address unit at a back offset of one gives wp - 1.
                    if (ram_rdata.session == r_sid && ram_rdata.kind == KIND_EVENT) begin
                        n_wp     = phys;
                        n_fill   = r_fill - CW'(1);
                        n_res.ok = 1'b1;
                    end
                end else if (r_type == REQ_READ) begin
                    n_res.ok  = 1'b1;
                    n_res.rec = ram_rdata;
                end else begin
                    if (ram_rdata.session != r_sid) begin
                        // Only the newest record may belong to another session.
                        if (r_back == CW'(1) && r_back < r_fill) begin
                            n_back  = r_back + CW'(1);
                            n_state = S_ISSUE;
                        end
                    end else if (ram_rdata.kind != want_kind) begin
                        if (r_back < r_fill) begin
                            n_back  = r_back + CW'(1);
                            n_state = S_ISSUE;
                        end
                    end else begin
                        ram_we           = 1'b1;
                        ram_wdata.anchor = r_anc;
                        n_res.ok         = 1'b1;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_back      <= '0;
            r_next      <= 32'd1;
            r_vtm       <= VALID_TIME_MIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_back      <= n_back;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vtm <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_type <= i_req.req_type;
            r_sid  <= i_req.session_id;
            r_el   <= i_req.elapsed_sec;
            r_anc  <= i_req.anchor_epoch;
            r_idx  <= i_req.read_index;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    // The fill count never exceeds the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= LOG_DEPTH)
        else $error("fill count beyond ring depth");

    // An append always moves the write pointer.
    a_append_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE && is_append) |=> (r_wp != $past(r_wp)))
        else $error("append did not advance the write pointer");

    // Leaving the done state always leaves a response word waiting.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> r_out_valid)
        else $error("response word lost on completion");

    // The walk never looks further back than the records held.
    a_back_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_back != '0 && r_back <= r_fill))
        else $error("back offset outside the filled records");

endmodule

/* tb/sv/ring_log_check_pkg.sv */
package ring_log_check_pkg;

    import setrl_pkg::*;

    // Request code outside the defined set; the block must refuse it.
    localparam logic [2:0] REQ_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] session_id;
        logic [31:0] elapsed_sec;
        logic [31:0] anchor_epoch;
        logic [7:0]  read_index;
    } t_request;

    // Mirror of the ring log: it replays every accepted request against its own
    // copy of the ring and queues the response word the block should return.
    class ring_log_mirror;
        t_rec        ring [DEF_LOG_DEPTH];
        logic [7:0]  wr_ptr;
        logic [8:0]  fill;
        logic [31:0] next_id;
        logic [31:0] time_floor;
        logic [31:0] last_given_id;
        t_result     awaited_replies [$];
        int unsigned errors;
        int unsigned replies_checked;
        int unsigned overwrites;
        int unsigned anchors_rewritten;
        int unsigned reads_ok;
        int unsigned deletes_ok;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_ptr            = '0;
            fill              = '0;
            next_id           = 32'd1;
            time_floor        = VALID_TIME_MIN_RESET;
            last_given_id     = '0;
            errors            = 0;
            replies_checked   = 0;
            overwrites        = 0;
            anchors_rewritten = 0;
            reads_ok          = 0;
            deletes_ok        = 0;
        endfunction

        function int unsigned pending();
            return awaited_replies.size();
        endfunction

        // Physical slot of a chronological position, 0 being the oldest record.
        function logic [7:0] slot_of(logic [8:0] chrono);
            logic [7:0] oldest;
            oldest = wr_ptr - fill[7:0];
            return oldest + chrono[7:0];
        endfunction

        function void append(logic [1:0] what, logic [31:0] sid, logic [31:0] el,
                             logic [31:0] anc);
            ring[wr_ptr] = '{session: sid, elapsed: el, anchor: anc, kind: what};
            wr_ptr = wr_ptr + 8'd1;
            if (fill < DEF_LOG_DEPTH) begin
                fill = fill + 9'd1;
            end else begin
                overwrites++;
            end
        endfunction

        function logic rewrite_anchor(logic [31:0] sid, logic [1:0] what, logic [31:0] anc);
            logic [7:0] p;
            if (anc <= time_floor || fill == 9'd0) return 1'b0;
            for (int back = 0; back < fill; back++) begin
                p = slot_of(fill - 9'd1 - 9'(back));
                if (ring[p].session != sid) begin
                    // Only the newest record may belong to a foreign session.
                    if (back > 0) return 1'b0;
                    continue;
                end
                if (ring[p].kind != what) continue;
                ring[p].anchor = anc;
                anchors_rewritten++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_request(t_request r);
            t_result     reply;
            logic [31:0] id;
            logic [7:0]  p;
            reply = '0;
            case (r.req_type)
                REQ_START: begin
                    id      = next_id;
                    next_id = next_id + 32'd1;
                    if (id == 32'd0) begin
                        id      = 32'd1;
                        next_id = 32'd2;
                    end
                    append(KIND_START, id, 32'd0, r.anchor_epoch);
                    last_given_id        = id;
                    reply.ok             = 1'b1;
                    reply.new_session_id = id;
                end
                REQ_EVENT: begin
                    append(KIND_EVENT, r.session_id, r.elapsed_sec, 32'd0);
                    reply.ok = 1'b1;
                end
                REQ_END: begin
                    append(KIND_END, r.session_id, r.elapsed_sec, r.anchor_epoch);
                    reply.ok = 1'b1;
                end
                REQ_DELETE: begin
                    if (fill != 9'd0) begin
                        p = slot_of(fill - 9'd1);
                        if (ring[p].session == r.session_id && ring[p].kind == KIND_EVENT) begin
                            wr_ptr   = wr_ptr - 8'd1;
                            fill     = fill - 9'd1;
                            reply.ok = 1'b1;
                            deletes_ok++;
                        end
                    end
                end
                REQ_READ: begin
                    if ({1'b0, r.read_index} < fill) begin
                        p         = slot_of({1'b0, r.read_index});
                        reply.ok  = 1'b1;
                        reply.rec = ring[p];
                        reads_ok++;
                    end
                end
                REQ_UPD_START: begin
                    reply.ok = rewrite_anchor(r.session_id, KIND_START, r.anchor_epoch);
                end
                REQ_UPD_END: begin
                    reply.ok = rewrite_anchor(r.session_id, KIND_END, r.anchor_epoch);
                end
                default: begin
                end
            endcase
            awaited_replies.push_back(reply);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
                errors++;
            end
        endfunction

        function void match_reply(t_result got);
            t_result want;
            if (awaited_replies.size() == 0) begin
                $error("response word arrived with no request outstanding (ok=%0b)", got.ok);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            replies_checked++;
            check_field("ok", want.ok, got.ok);
            check_field("new_session_id", want.new_session_id, got.new_session_id);
            check_field("rec_session", want.rec.session, got.rec.session);
            check_field("rec_elapsed", want.rec.elapsed, got.rec.elapsed);
            check_field("rec_anchor", want.rec.anchor, got.rec.anchor);
            check_field("rec_kind", want.rec.kind, got.rec.kind);
        endfunction
    endclass

endpackage

/* tb/sv/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import setrl_pkg::*;
    import ring_log_check_pkg::*;

    // Random requests per threshold setting; five settings give about 1700.
    localparam int unsigned  RANDOM_PER_PHASE = 340;
    // The slowest legal run has every request walk the full ring behind the
    // longest receiver stall and sender gap. The guard is several times that.
    localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;
    // Quiet cycles after the last response, covering the longest anchor walk.
    localparam int unsigned  TAIL_CYCLES = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    setrl_req_if req_bus ();
    setrl_rsp_if rsp_bus ();

    ring_log_mirror  mirror;
    longint unsigned cycles = 0;
    int unsigned     burst_left;
    int unsigned     requests_sent;
    int unsigned     floors_used;
    // Set while the generator has an open session that it is still filling.
    bit              in_session;

    session_tagged_event_ring_log dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung block: a run that never drains ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d responses outstanding.",
                     mirror.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Every response word taken by the receiver is compared with the oldest
    // prediction. Sampling happens at the rising edge, before the block's own
    // updates of that edge land.
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            seen.ok             = rsp_bus.ok;
            seen.new_session_id = rsp_bus.new_session_id;
            seen.rec.session    = rsp_bus.rec_session;
            seen.rec.elapsed    = rsp_bus.rec_elapsed;
            seen.rec.anchor     = rsp_bus.rec_anchor;
            seen.rec.kind       = rsp_bus.rec_kind;
            mirror.match_reply(seen);
        end
    end

    // The receiver switches between stretches of steady acceptance, random
    // back-pressure and rare long stalls, so that the output register of the
    // block is held while further requests pile up behind it.
    initial begin
        int unsigned hold;
        int unsigned mode;
        int unsigned mode_left;
        rsp_bus.ready = 1'b0;
        hold          = 0;
        mode          = 0;
        mode_left     = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold != 0) begin
                hold--;
                rsp_bus.ready = 1'b0;
            end else begin
                case (mode)
                    0: begin
                        rsp_bus.ready = 1'b1;
                    end
                    1: begin
                        rsp_bus.ready = ($urandom_range(0, 99) < 65);
                    end
                    default: begin
                        if ($urandom_range(0, 9) == 0) begin
                            hold          = $urandom_range(0, 29);
                            rsp_bus.ready = 1'b0;
                        end else begin
                            rsp_bus.ready = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    function automatic t_request make_req(logic [2:0] code, logic [31:0] sid,
                                          logic [31:0] el, logic [31:0] anc,
                                          logic [7:0] idx);
        t_request r;
        r.req_type     = code;
        r.session_id   = sid;
        r.elapsed_sec  = el;
        r.anchor_epoch = anc;
        r.read_index   = idx;
        return r;
    endfunction

    // Anchor values cluster around the current threshold so that both sides
    // of the "strictly above" rule are hit often.
    function automatic logic [31:0] pick_anchor();
        case ($urandom_range(0, 9))
            0: return mirror.time_floor;
            1: return mirror.time_floor + 32'd1;
            2: return mirror.time_floor - 32'd1;
            3: return 32'd0;
            4: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Most requests follow a well-formed session: a start, then events,
    // deletes of the last event, anchor updates and reads in range, closed by
    // an end. The rest is noise with a random code, the unknown code too.
    function automatic t_request make_request();
        t_request    r;
        int unsigned roll;
        r = make_req(REQ_EVENT, mirror.last_given_id, $urandom(), pick_anchor(),
                     8'($urandom()));
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            r.req_type = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1) begin
                r.session_id = $urandom();
            end else begin
                r.session_id = mirror.last_given_id - 32'($urandom_range(0, 3));
            end
            return r;
        end
        if (!in_session) begin
            r.req_type = REQ_START;
            in_session = 1'b1;
            return r;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            r.req_type = REQ_EVENT;
        end else if (roll < 57) begin
            r.req_type = REQ_DELETE;
        end else if (roll < 67) begin
            r.req_type = REQ_END;
            in_session = 1'b0;
        end else if (roll < 75) begin
            r.req_type = REQ_UPD_START;
        end else if (roll < 80) begin
            r.req_type = REQ_UPD_END;
        end else begin
            r.req_type = REQ_READ;
            if (mirror.fill != 9'd0) begin
                r.read_index = 8'($urandom_range(0, mirror.fill - 1));
            end
        end
        return r;
    endfunction

    // Presents one request word at the falling edge and holds it until the
    // block takes it. Valid stays high on return so that a following word can
    // go out back to back.
    task automatic send_request(input t_request r);
        @(negedge i_clk);
        req_bus.valid        = 1'b1;
        req_bus.req_type     = r.req_type;
        req_bus.session_id   = r.session_id;
        req_bus.elapsed_sec  = r.elapsed_sec;
        req_bus.anchor_epoch = r.anchor_epoch;
        req_bus.read_index   = r.read_index;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        mirror.take_request(r);
        requests_sent++;
    endtask

    task automatic idle_sender(input int unsigned gap);
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        if (gap > 1) repeat (gap - 1) @(negedge i_clk);
    endtask

    // Bursts of random length separated by random gaps; some bursts are long
    // enough to give stretches without any idling.
    task automatic pace();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(60, 200);
            end else begin
                burst_left = $urandom_range(1, 25);
            end
            idle_sender($urandom_range(1, 20));
        end
    endtask

    // Holds the sender off until every predicted response has been taken.
    task automatic drain();
        idle_sender(1);
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    // The threshold is only changed while the block is idle.
    task automatic set_time_floor(input logic [31:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        mirror.time_floor = value;
        floors_used++;
    endtask

    initial begin
        t_request    script [$];
        logic [31:0] floors [5];

        mirror               = new();
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_START;
        req_bus.session_id   = '0;
        req_bus.elapsed_sec  = '0;
        req_bus.anchor_epoch = '0;
        req_bus.read_index   = '0;
        in_session           = 1'b0;
        burst_left           = 0;
        requests_sent        = 0;
        floors_used          = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening, run under the reset value of the threshold.
        // Everything on an empty ring must be refused, as must the unknown code.
        script.push_back(make_req(REQ_READ, 32'd0, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_DELETE, 32'd0, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_UPD_START, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0));
        script.push_back(make_req(REQ_UPD_END, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0));
        script.push_back(make_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 8'hFF));
        // Session 1: a delete of a foreign session is refused, the matching one
        // pops the event, and a start record is never popped.
        script.push_back(make_req(REQ_START, 32'd0, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_EVENT, 32'd1, 32'hFFFF_FFFF, 32'd0, 8'd0));
        script.push_back(make_req(REQ_DELETE, 32'd2, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_DELETE, 32'd1, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_DELETE, 32'd1, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_EVENT, 32'd1, 32'd5, 32'd0, 8'd0));
        script.push_back(make_req(REQ_END, 32'd1, 32'd7, 32'hFFFF_FFFF, 8'd0));
        // An anchor equal to the threshold is refused, one above it is taken.
        script.push_back(make_req(REQ_UPD_START, 32'd1, 32'd0, VALID_TIME_MIN_RESET, 8'd0));
        script.push_back(make_req(REQ_UPD_START, 32'd1, 32'd0,
                                  VALID_TIME_MIN_RESET + 32'd1, 8'd0));
        script.push_back(make_req(REQ_UPD_END, 32'd1, 32'd0, 32'd2_000_000_000, 8'd0));
        // A foreign record on top is stepped over by the anchor search.
        script.push_back(make_req(REQ_EVENT, 32'hDEAD_BEEF, 32'd3, 32'd0, 8'd0));
        script.push_back(make_req(REQ_UPD_START, 32'd1, 32'd0, 32'd3_000_000_000, 8'd0));
        // A foreign record further down ends the search.
        script.push_back(make_req(REQ_START, 32'd0, 32'd0, 32'd12345, 8'd0));
        script.push_back(make_req(REQ_EVENT, 32'd1, 32'd9, 32'd0, 8'd0));
        script.push_back(make_req(REQ_UPD_START, 32'd1, 32'd0, 32'd3_000_000_000, 8'd0));
        // Reads at and past the fill count, then the oldest and newest records.
        script.push_back(make_req(REQ_READ, 32'd0, 32'd0, 32'd0, 8'd6));
        script.push_back(make_req(REQ_READ, 32'd0, 32'd0, 32'd0, 8'd255));
        script.push_back(make_req(REQ_READ, 32'd0, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_READ, 32'd0, 32'd0, 32'd0, 8'd5));
        script.push_back(make_req(REQ_DELETE, 32'd1, 32'd0, 32'd0, 8'd0));
        script.push_back(make_req(REQ_UPD_END, 32'd2, 32'd0, 32'd4_000_000_000, 8'd0));
        foreach (script[i]) send_request(script[i]);

        // Random phases, each under its own threshold: both extremes, the
        // reset value and two random ones. The ring fills early and then
        // keeps overwriting its oldest records.
        floors[0] = 32'd0;
        floors[1] = 32'hFFFF_FFFF;
        floors[2] = $urandom();
        floors[3] = VALID_TIME_MIN_RESET;
        floors[4] = 32'($urandom_range(0, 100));
        foreach (floors[ph]) begin
            set_time_floor(floors[ph]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_request(make_request());
                if ($urandom_range(0, 199) == 0) begin
                    drain();
                end else begin
                    pace();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d response words under %0d thresholds.",
                 requests_sent, mirror.replies_checked, floors_used);
        $display("Oldest record overwritten %0d times; %0d reads, %0d deletes, %0d anchor %s",
                 mirror.overwrites, mirror.reads_ok, mirror.deletes_ok,
                 mirror.anchors_rewritten, "rewrites succeeded.");
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
